/* rtl/core/prhe_pkg.sv */
// ---------------------------------------------------------------------------
// prhe_pkg
// Shared constants and types of the prefix rolling hash engine: store size,
// command and status codes, register indexes and the request bundle of the
// serial modular multiplier.
// ---------------------------------------------------------------------------
package prhe_pkg;

	// text store size
	localparam int MAX_LEN = 1024;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = $clog2(MAX_LEN);

	// hash arithmetic width
	localparam int DATA_W    = 31;
	localparam int CHAR_W    = 8;
	localparam int MUL_STEPS = DATA_W;
	localparam int STEP_W    = $clog2(MUL_STEPS + 1);

	// command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// configuration registers
	localparam int          CFG_IDX_W   = 1;
	localparam logic [0:0]  CFG_MODULUS = 1'd0;
	localparam logic [0:0]  CFG_BASE    = 1'd1;
	localparam logic [30:0] MODULUS_RST = 31'd1000000007;
	localparam logic [30:0] BASE_RST    = 31'd31;
	localparam logic [30:0] MODULUS_MIN = 31'd2;

	// request to the serial multiplier: result = (a * b) mod m, b below m
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] m;
	} mm_req_t;

endpackage

/* rtl/core/prhe_mulmod.sv */
// ---------------------------------------------------------------------------
// prhe_mulmod
// Bit-serial modular multiplier. Walks the multiplicand MSB first, one bit a
// cycle: r = 2r + bit*b, then reduced below m by picking among r, r-m, r-2m.
// The multiplicand may be any value; b must already sit below m.
// ---------------------------------------------------------------------------
module prhe_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prhe_pkg::mm_req_t             req,
	output logic                          busy,
	output logic [prhe_pkg::DATA_W-1:0]   result
);

	logic [prhe_pkg::DATA_W-1:0] a_sh_q;
	logic [prhe_pkg::DATA_W-1:0] b_q;
	logic [prhe_pkg::DATA_W-1:0] m_q;
	logic [prhe_pkg::DATA_W-1:0] r_q;
	logic [prhe_pkg::STEP_W-1:0] cnt_q;

	logic [prhe_pkg::DATA_W+1:0] t_sum;
	logic [prhe_pkg::DATA_W+2:0] d1;
	logic [prhe_pkg::DATA_W+2:0] d2;
	logic [prhe_pkg::DATA_W-1:0] r_next;

	// one double-and-add step, three candidates side by side
	always_comb begin
		t_sum = {1'b0, r_q, 1'b0} + (a_sh_q[prhe_pkg::DATA_W-1] ? {2'b00, b_q} : '0);
		d1    = {1'b0, t_sum} - {3'b000, m_q};
		d2    = {1'b0, t_sum} - {2'b00, m_q, 1'b0};
		if (!d2[prhe_pkg::DATA_W+2]) begin
			r_next = d2[prhe_pkg::DATA_W-1:0];
		end else if (!d1[prhe_pkg::DATA_W+2]) begin
			r_next = d1[prhe_pkg::DATA_W-1:0];
		end else begin
			r_next = t_sum[prhe_pkg::DATA_W-1:0];
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= prhe_pkg::STEP_W'(prhe_pkg::MUL_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - prhe_pkg::STEP_W'(1);
		end
	end

	// operand shift register and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_sh_q <= req.a;
			b_q    <= req.b;
			m_q    <= req.m;
			r_q    <= '0;
		end else if (cnt_q != '0) begin
			a_sh_q <= {a_sh_q[prhe_pkg::DATA_W-2:0], 1'b0};
			r_q    <= r_next;
		end
	end

	assign busy   = (cnt_q != '0);
	assign result = r_q;

endmodule

/* rtl/core/prefix_rolling_hash_engine.sv */
// ---------------------------------------------------------------------------
// prefix_rolling_hash_engine
// Polynomial rolling hash over a stored text with substring-hash queries.
// Prefix hashes and base powers live in two memories with one read and one write
// port each; all modular products run through two bit-serial multipliers.
// ---------------------------------------------------------------------------
// Append and query each take two passes of the 31-step serial multipliers,
// query after a memory read state; all other items go straight to the result.
// Throughput: one item at a time, next accept in the cycle after the result is
// loaded; a stalled result lets one more item finish, then the input stalls.
// Reset clears length, handshake state and restores modulus and base;
// store entry zero reads as hash zero and power one, no clearing pass.
module prefix_rolling_hash_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [prhe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prhe_pkg::DATA_W-1:0]        cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic signed [prhe_pkg::CHAR_W-1:0] char_value,
	input  logic [prhe_pkg::LEN_W-1:0]         query_start,
	input  logic [prhe_pkg::LEN_W-1:0]         query_end,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [prhe_pkg::DATA_W-1:0]        hash_value,
	output logic [1:0]                         status,
	output logic [prhe_pkg::LEN_W-1:0]         text_length
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP1,
		ST_APP2,
		ST_QRD,
		ST_Q1,
		ST_Q2,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [prhe_pkg::DATA_W-1:0] modulus_q;
	logic [prhe_pkg::DATA_W-1:0] base_q;
	logic [prhe_pkg::DATA_W-1:0] m_eff;

	logic [prhe_pkg::LEN_W-1:0]  len_q;
	logic [prhe_pkg::LEN_W-1:0]  qs_q;
	logic                        char_neg_q;
	logic [prhe_pkg::DATA_W-1:0] cr_q;
	logic [prhe_pkg::DATA_W-1:0] res_hash_q;
	logic [1:0]                  res_status_q;

	// memories for entries 1..MAX_LEN, entry zero is a constant
	logic [prhe_pkg::DATA_W-1:0] h_mem [prhe_pkg::MAX_LEN];
	logic [prhe_pkg::DATA_W-1:0] p_mem [prhe_pkg::MAX_LEN];
	logic [prhe_pkg::DATA_W-1:0] h_rdata_q;
	logic [prhe_pkg::DATA_W-1:0] p_rdata_q;
	logic                        h_zero_q;
	logic                        p_zero_q;
	logic                        h_ren;
	logic                        p_ren;
	logic [prhe_pkg::LEN_W-1:0]  h_raddr;
	logic [prhe_pkg::LEN_W-1:0]  p_raddr;
	logic [prhe_pkg::LEN_W-1:0]  h_raddr_m1;
	logic [prhe_pkg::LEN_W-1:0]  p_raddr_m1;
	logic [prhe_pkg::DATA_W-1:0] h_rd;
	logic [prhe_pkg::DATA_W-1:0] p_rd;
	logic                        mem_we;
	logic [prhe_pkg::DATA_W-1:0] h_wdata;

	// serial multipliers
	prhe_pkg::mm_req_t           req_a;
	prhe_pkg::mm_req_t           req_b;
	logic                        a_busy;
	logic                        b_busy;
	logic [prhe_pkg::DATA_W-1:0] a_res;
	logic [prhe_pkg::DATA_W-1:0] b_res;
	logic                        mm_done;

	// decode of the offered beat
	logic                        in_accept;
	logic                        range_bad;
	logic                        store_full;
	logic [prhe_pkg::LEN_W-1:0]  sub_len;
	logic [prhe_pkg::DATA_W-1:0] char_mag;
	logic [prhe_pkg::DATA_W-1:0] cr_adj;
	logic [prhe_pkg::DATA_W:0]   app_sum;
	logic [prhe_pkg::DATA_W:0]   app_diff;
	logic [prhe_pkg::DATA_W:0]   q_diff;
	logic [prhe_pkg::DATA_W-1:0] q_hash;
	logic                        out_free;

	assign m_eff     = (modulus_q < prhe_pkg::MODULUS_MIN) ? prhe_pkg::MODULUS_MIN : modulus_q;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign mm_done   = !a_busy && !b_busy;
	assign out_free  = !out_valid || !out_stall;

	assign range_bad  = (query_start > query_end) || (query_end > len_q);
	assign store_full = (len_q >= prhe_pkg::LEN_W'(prhe_pkg::MAX_LEN));
	assign sub_len    = query_end - query_start;

	// negative characters are reduced through their magnitude minus one
	assign char_mag = char_value[prhe_pkg::CHAR_W-1]
		? {{(prhe_pkg::DATA_W-prhe_pkg::CHAR_W){1'b0}}, ~char_value}
		: {{(prhe_pkg::DATA_W-prhe_pkg::CHAR_W){1'b0}}, char_value};
	assign cr_adj = char_neg_q ? (m_eff - prhe_pkg::DATA_W'(1) - b_res) : b_res;

	// h[n+1] = t + c mod m
	assign app_sum  = {1'b0, a_res} + {1'b0, cr_q};
	assign app_diff = app_sum - {1'b0, m_eff};
	assign h_wdata  = app_diff[prhe_pkg::DATA_W] ? app_sum[prhe_pkg::DATA_W-1:0]
		: app_diff[prhe_pkg::DATA_W-1:0];

	// he - sub mod m
	assign q_diff = {1'b0, b_res} - {1'b0, a_res};
	assign q_hash = q_diff[prhe_pkg::DATA_W] ? (q_diff[prhe_pkg::DATA_W-1:0] + m_eff)
		: q_diff[prhe_pkg::DATA_W-1:0];

	// memory read ports and multiplier requests
	always_comb begin
		h_ren   = 1'b0;
		p_ren   = 1'b0;
		h_raddr = len_q;
		p_raddr = len_q;
		req_a   = '0;
		req_b   = '0;
		req_a.m = m_eff;
		req_b.m = m_eff;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && (cmd == prhe_pkg::CMD_APPEND) && !store_full) begin
					h_ren       = 1'b1;
					p_ren       = 1'b1;
					req_a.start = 1'b1;
					req_a.a     = base_q;
					req_a.b     = prhe_pkg::DATA_W'(1);
					req_b.start = 1'b1;
					req_b.a     = char_mag;
					req_b.b     = prhe_pkg::DATA_W'(1);
				end else if (in_accept && (cmd == prhe_pkg::CMD_QUERY) && !range_bad) begin
					h_ren   = 1'b1;
					p_ren   = 1'b1;
					h_raddr = query_end;
					p_raddr = sub_len;
				end
			end
			ST_QRD: begin
				h_ren       = 1'b1;
				h_raddr     = qs_q;
				req_a.start = 1'b1;
				req_a.a     = p_rd;
				req_a.b     = prhe_pkg::DATA_W'(1);
				req_b.start = 1'b1;
				req_b.a     = h_rd;
				req_b.b     = prhe_pkg::DATA_W'(1);
			end
			ST_Q1: begin
				if (mm_done) begin
					req_a.start = 1'b1;
					req_a.a     = h_rd;
					req_a.b     = a_res;
				end
			end
			ST_APP1: begin
				if (mm_done) begin
					req_a.start = 1'b1;
					req_a.a     = h_rd;
					req_a.b     = a_res;
					req_b.start = 1'b1;
					req_b.a     = p_rd;
					req_b.b     = a_res;
				end
			end
			ST_APP2, ST_Q2, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign h_raddr_m1 = h_raddr - prhe_pkg::LEN_W'(1);
	assign p_raddr_m1 = p_raddr - prhe_pkg::LEN_W'(1);
	assign mem_we     = (state_q == ST_APP2) && mm_done;

	// prefix hash memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			h_mem[len_q[prhe_pkg::ADDR_W-1:0]] <= h_wdata;
		end
		if (h_ren) begin
			h_rdata_q <= h_mem[h_raddr_m1[prhe_pkg::ADDR_W-1:0]];
		end
	end

	// power memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			p_mem[len_q[prhe_pkg::ADDR_W-1:0]] <= b_res;
		end
		if (p_ren) begin
			p_rdata_q <= p_mem[p_raddr_m1[prhe_pkg::ADDR_W-1:0]];
		end
	end

	// entry zero flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_zero_q <= 1'b0;
			p_zero_q <= 1'b0;
		end else begin
			if (h_ren) begin
				h_zero_q <= (h_raddr == '0);
			end
			if (p_ren) begin
				p_zero_q <= (p_raddr == '0);
			end
		end
	end

	assign h_rd = h_zero_q ? '0 : h_rdata_q;
	assign p_rd = p_zero_q ? prhe_pkg::DATA_W'(1) : p_rdata_q;

	prhe_mulmod u_mm_a (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_a),
		.busy   (a_busy),
		.result (a_res)
	);

	prhe_mulmod u_mm_b (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_b),
		.busy   (b_busy),
		.result (b_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= prhe_pkg::MODULUS_RST;
			base_q    <= prhe_pkg::BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prhe_pkg::CFG_MODULUS: modulus_q <= cfg_data;
				prhe_pkg::CFG_BASE:    base_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer, text length and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// result beat: load when finishing, drop once taken
			if ((state_q == ST_FIN) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						res_hash_q   <= '0;
						res_status_q <= prhe_pkg::STATUS_OK;
						qs_q         <= query_start;
						char_neg_q   <= char_value[prhe_pkg::CHAR_W-1];
						state_q      <= ST_FIN;
						case (cmd)
							prhe_pkg::CMD_APPEND: begin
								if (store_full) begin
									res_status_q <= prhe_pkg::STATUS_FULL;
								end else begin
									state_q <= ST_APP1;
								end
							end
							prhe_pkg::CMD_QUERY: begin
								if (range_bad) begin
									res_status_q <= prhe_pkg::STATUS_RANGE;
								end else begin
									state_q <= ST_QRD;
								end
							end
							prhe_pkg::CMD_CLEAR: begin
								len_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_APP1: begin
					if (mm_done) begin
						cr_q    <= cr_adj;
						state_q <= ST_APP2;
					end
				end
				ST_APP2: begin
					if (mm_done) begin
						len_q   <= len_q + prhe_pkg::LEN_W'(1);
						state_q <= ST_FIN;
					end
				end
				ST_QRD: begin
					state_q <= ST_Q1;
				end
				ST_Q1: begin
					if (mm_done) begin
						state_q <= ST_Q2;
					end
				end
				ST_Q2: begin
					if (mm_done) begin
						res_hash_q <= q_hash;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						hash_value  <= res_hash_q;
						status      <= res_status_q;
						text_length <= len_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/prhe_checker.sv */
// ---------------------------------------------------------------------------
// prhe_checker
// Port-level checks of the prefix rolling hash engine, bound to the top
// level: result hold under stall, one item at a time, status consistency.
// ---------------------------------------------------------------------------
module prhe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [prhe_pkg::DATA_W-1:0] hash_value,
	input logic [1:0]                  status,
	input logic [prhe_pkg::LEN_W-1:0]  text_length
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value) && $stable(status)
			&& $stable(text_length))
		else $error("result beat changed while stalled");

	// one item in flight: an accept closes the input side
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// rejected items carry no hash
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != prhe_pkg::STATUS_OK) |-> hash_value == '0)
		else $error("error status with nonzero hash");

	// full status only at capacity
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == prhe_pkg::STATUS_FULL)
			|-> text_length == prhe_pkg::LEN_W'(prhe_pkg::MAX_LEN))
		else $error("store full reported below capacity");

	// status code and length in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == prhe_pkg::STATUS_OK) || (status == prhe_pkg::STATUS_RANGE)
			|| (status == prhe_pkg::STATUS_FULL))
			&& (text_length <= prhe_pkg::LEN_W'(prhe_pkg::MAX_LEN)))
		else $error("status or length out of range");

endmodule

bind prefix_rolling_hash_engine prhe_checker u_prhe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hash_value  (hash_value),
	.status      (status),
	.text_length (text_length)
);
